/* design/gvba_pkg.sv */
// Package for the grid vector bin averaging block: payload structs, mesh
// constants, controller state type and the controller/datapath command links.
// No dependencies.
`default_nettype none
package gvba_pkg;

   localparam int MESH_Y      = 32;
   localparam int MESH_Z      = 32;
   localparam int GRID_PITCH  = 16;
   localparam int WINDOW_HALF = 5;

   localparam int CELLS  = MESH_Y * MESH_Z;
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   // bin windows in Q12.4 units
   localparam int BIN_STEP = GRID_PITCH * 16;
   localparam int BIN_OFF  = WINDOW_HALF * 16;
   localparam int BIN_SPAN = 2 * BIN_OFF;

   localparam int DIV_STEPS  = 33;
   localparam int SQRT_STEPS = 24;
   localparam int ITER_W     = 6;

   localparam logic [1:0] CSR_QUALITY_MIN = 2'd0;
   localparam logic [1:0] CSR_QUALITY_MAX = 2'd1;
   localparam logic [1:0] CSR_SPEED_SCALE = 2'd2;
   localparam logic [1:0] CSR_SPEED_LIMIT = 2'd3;

   typedef struct packed {
      logic               mode;
      logic [15:0]        pos_y;
      logic [15:0]        pos_z;
      logic signed [15:0] disp_y;
      logic signed [15:0] disp_z;
      logic [15:0]        quality;
      logic [4:0]         query_y;
      logic [4:0]         query_z;
   } req_type;

   typedef struct packed {
      logic               binned;
      logic [4:0]         hit_y;
      logic [4:0]         hit_z;
      logic signed [15:0] mean_y;
      logic signed [15:0] mean_z;
      logic [15:0]        speed;
      logic               rejected;
      logic               empty_res;
      logic [31:0]        vector_total;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] sum_y;
      logic signed [31:0] sum_z;
      logic [15:0]        count;
   } cell_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_MEAN,
      ST_SQ,
      ST_SQRT,
      ST_MUL,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clr_wr;
      logic capture;
      logic accum;
      logic mark_empty;
      logic div_init;
      logic div_step;
      logic mean_calc;
      logic sq_calc;
      logic sqrt_step;
      logic mul_calc;
      logic fin_calc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mode;
      logic empty;
      logic div_last;
      logic sqrt_last;
   } sts_type;

endpackage
`default_nettype wire

/* design/gvba_ctrl.sv */
// Controller for the grid vector bin averaging block: clear sweep, item
// sequencing and the result valid flag. Depends on gvba_pkg.
`default_nettype none
module gvba_ctrl import gvba_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ: begin
            if (!sts.mode || sts.empty) state_in = ST_DONE;
            else state_in = ST_DIV;
         end
         ST_DIV:   if (sts.div_last) state_in = ST_MEAN;
         ST_MEAN:  state_in = ST_SQ;
         ST_SQ:    state_in = ST_SQRT;
         ST_SQRT:  if (sts.sqrt_last) state_in = ST_MUL;
         ST_MUL:   state_in = ST_FIN;
         ST_FIN:   state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_IDLE:  cmd.capture = req_valid;
         ST_READ: begin
            cmd.accum      = !sts.mode;
            cmd.mark_empty = sts.mode && sts.empty;
            cmd.div_init   = sts.mode && !sts.empty;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_MEAN:  cmd.mean_calc = 1'b1;
         ST_SQ:    cmd.sq_calc = 1'b1;
         ST_SQRT:  cmd.sqrt_step = 1'b1;
         ST_MUL:   cmd.mul_calc = 1'b1;
         ST_FIN:   cmd.fin_calc = 1'b1;
         ST_DONE:  cmd.out_load = !rsp_valid_ff || !rsp_stall;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* design/gvba_dp.sv */
// Datapath for the grid vector bin averaging block: cell memory, binning,
// accumulate, bit-serial dividers and square root, speed scaling, CSRs.
// Depends on gvba_pkg.
`default_nettype none
module gvba_dp import gvba_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire req_type     req_data,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   cell_type mem [CELLS];
   cell_type rd_ff;

   logic [15:0] qmin_ff, qmax_ff, limit_ff;
   logic [23:0] scale_ff;

   logic [CELL_W-1:0] clr_ff;
   logic [CELL_W-1:0] addr_ff;
   logic              mode_ff, ok_ff, oob_ff;
   logic [4:0]        hy_ff, hz_ff;
   logic signed [15:0] dy_ff, dz_ff;
   logic [31:0]       total_ff;

   // result fields
   logic               binned_ff, rejected_ff, empty_ff;
   logic [4:0]         hit_y_ff, hit_z_ff;
   logic signed [15:0] mean_y_ff, mean_z_ff;
   logic [15:0]        speed_ff;
   rsp_type            rsp_ff;

   // division lanes: num shifts out dividend, shifts in quotient
   logic [32:0] num_y_ff, num_z_ff;
   logic [16:0] rem_y_ff, rem_z_ff, den_ff;
   logic        neg_y_ff, neg_z_ff;
   logic [ITER_W-1:0] iter_ff;

   logic [15:0] mag_y_ff, mag_z_ff;
   logic [47:0] sx_ff, sr_ff, sbit_ff;
   logic [47:0] prod_ff;

   // binning
   function automatic logic [8:0] bin_of(input logic [15:0] pos, input int n);
      logic [16:0] sh;
      logic [16:0] idx;
      logic [16:0] rem;
      sh  = {1'b0, pos} + 17'(BIN_OFF);
      idx = 17'(sh / BIN_STEP);
      rem = 17'(sh % BIN_STEP);
      bin_of = {(rem < 17'(BIN_SPAN)) && (idx < 17'(n)), idx[7:0]};
   endfunction

   logic [8:0]        bin_y, bin_z;
   logic [CELL_W-1:0] acc_addr, qry_addr, rd_addr;
   logic              q_ok, qry_oob;

   always_comb begin
      bin_y    = bin_of(req_data.pos_y, MESH_Y);
      bin_z    = bin_of(req_data.pos_z, MESH_Z);
      q_ok     = (qmin_ff <= req_data.quality) && (req_data.quality <= qmax_ff);
      acc_addr = CELL_W'(32'(bin_y[7:0]) * MESH_Z + 32'(bin_z[7:0]));
      qry_addr = CELL_W'(32'(req_data.query_y) * MESH_Z + 32'(req_data.query_z));
      qry_oob  = (32'(req_data.query_y) >= MESH_Y) || (32'(req_data.query_z) >= MESH_Z);
      rd_addr  = req_data.mode ? qry_addr : acc_addr;
   end

   // accumulate with saturation
   cell_type    upd;
   logic [32:0] ty, tz;
   always_comb begin
      ty = {rd_ff.sum_y[31], rd_ff.sum_y} + {{17{dy_ff[15]}}, dy_ff};
      tz = {rd_ff.sum_z[31], rd_ff.sum_z} + {{17{dz_ff[15]}}, dz_ff};
      upd.sum_y = (ty[32] != ty[31]) ? {ty[32], {31{!ty[32]}}} : ty[31:0];
      upd.sum_z = (tz[32] != tz[31]) ? {tz[32], {31{!tz[32]}}} : tz[31:0];
      upd.count = (rd_ff.count == 16'hFFFF) ? rd_ff.count : rd_ff.count + 16'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) mem[clr_ff] <= '0;
      else if (cmd.accum && ok_ff) mem[addr_ff] <= upd;
      rd_ff <= mem[rd_addr];
   end

   // division setup
   logic [31:0] abs_y, abs_z;
   always_comb begin
      abs_y = rd_ff.sum_y[31] ? 32'(-rd_ff.sum_y) : rd_ff.sum_y;
      abs_z = rd_ff.sum_z[31] ? 32'(-rd_ff.sum_z) : rd_ff.sum_z;
   end

   logic [17:0] sh_y, sh_z;
   logic        ge_y, ge_z;
   always_comb begin
      sh_y = {rem_y_ff, num_y_ff[32]};
      sh_z = {rem_z_ff, num_z_ff[32]};
      ge_y = sh_y >= {1'b0, den_ff};
      ge_z = sh_z >= {1'b0, den_ff};
   end

   function automatic logic [15:0] sat_mag(input logic [32:0] q, input logic neg);
      logic [32:0] lim;
      lim = neg ? 33'd32768 : 33'd32767;
      sat_mag = (q > lim) ? lim[15:0] : q[15:0];
   endfunction

   logic [47:0] st;
   logic [48:0] rnd;
   logic [24:0] s_raw;
   logic [15:0] s_sat;
   always_comb begin
      st    = sr_ff + sbit_ff;
      rnd   = {1'b0, prod_ff} + 49'(24'h800000);
      s_raw = rnd[48:24];
      s_sat = (s_raw > 25'd65535) ? 16'hFFFF : s_raw[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         total_ff <= '0;
         qmin_ff  <= 16'd0;
         qmax_ff  <= 16'hFFFF;
         scale_ff <= 24'd65536;
         limit_ff <= 16'd640;
      end else begin
         if (cmd.clr_wr) clr_ff <= clr_ff + 1'b1;
         if (cmd.accum && ok_ff && total_ff != 32'hFFFF_FFFF) total_ff <= total_ff + 32'd1;
         if (csr_we) begin
            case (csr_index)
               CSR_QUALITY_MIN: qmin_ff  <= csr_data[15:0];
               CSR_QUALITY_MAX: qmax_ff  <= csr_data[15:0];
               CSR_SPEED_SCALE: scale_ff <= csr_data;
               CSR_SPEED_LIMIT: limit_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_data.mode;
         ok_ff       <= q_ok && bin_y[8] && bin_z[8];
         oob_ff      <= qry_oob;
         addr_ff     <= acc_addr;
         hy_ff       <= bin_y[4:0];
         hz_ff       <= bin_z[4:0];
         dy_ff       <= req_data.disp_y;
         dz_ff       <= req_data.disp_z;
         binned_ff   <= 1'b0;
         hit_y_ff    <= '0;
         hit_z_ff    <= '0;
         mean_y_ff   <= '0;
         mean_z_ff   <= '0;
         speed_ff    <= '0;
         rejected_ff <= 1'b0;
         empty_ff    <= 1'b0;
      end
      if (cmd.accum && ok_ff) begin
         binned_ff <= 1'b1;
         hit_y_ff  <= hy_ff;
         hit_z_ff  <= hz_ff;
      end
      if (cmd.mark_empty) empty_ff <= 1'b1;
      if (cmd.div_init) begin
         num_y_ff <= {abs_y, 1'b0} + 33'(rd_ff.count);
         num_z_ff <= {abs_z, 1'b0} + 33'(rd_ff.count);
         den_ff   <= {rd_ff.count, 1'b0};
         rem_y_ff <= '0;
         rem_z_ff <= '0;
         neg_y_ff <= rd_ff.sum_y[31];
         neg_z_ff <= rd_ff.sum_z[31];
         iter_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_y_ff <= ge_y ? 17'(sh_y - {1'b0, den_ff}) : sh_y[16:0];
         rem_z_ff <= ge_z ? 17'(sh_z - {1'b0, den_ff}) : sh_z[16:0];
         num_y_ff <= {num_y_ff[31:0], ge_y};
         num_z_ff <= {num_z_ff[31:0], ge_z};
         iter_ff  <= iter_ff + 1'b1;
      end
      if (cmd.mean_calc) begin
         mag_y_ff  <= sat_mag(num_y_ff, neg_y_ff);
         mag_z_ff  <= sat_mag(num_z_ff, neg_z_ff);
         mean_y_ff <= neg_y_ff ? -$signed(sat_mag(num_y_ff, neg_y_ff))
                               : $signed(sat_mag(num_y_ff, neg_y_ff));
         mean_z_ff <= neg_z_ff ? -$signed(sat_mag(num_z_ff, neg_z_ff))
                               : $signed(sat_mag(num_z_ff, neg_z_ff));
      end
      if (cmd.sq_calc) begin
         sx_ff   <= {(32'(mag_y_ff) * 32'(mag_y_ff)) + (32'(mag_z_ff) * 32'(mag_z_ff)),
                     16'h0000};
         sr_ff   <= '0;
         sbit_ff <= 48'h4000_0000_0000;
         iter_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         if (sx_ff >= st) begin
            sx_ff <= sx_ff - st;
            sr_ff <= (sr_ff >> 1) + sbit_ff;
         end else begin
            sr_ff <= sr_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.mul_calc) prod_ff <= 48'(sr_ff[23:0]) * 48'(scale_ff);
      if (cmd.fin_calc) begin
         if (s_sat >= limit_ff) begin
            rejected_ff <= 1'b1;
            mean_y_ff   <= '0;
            mean_z_ff   <= '0;
            speed_ff    <= '0;
         end else begin
            speed_ff <= s_sat;
         end
      end
      if (cmd.out_load) begin
         rsp_ff.binned       <= binned_ff;
         rsp_ff.hit_y        <= hit_y_ff;
         rsp_ff.hit_z        <= hit_z_ff;
         rsp_ff.mean_y       <= mean_y_ff;
         rsp_ff.mean_z       <= mean_z_ff;
         rsp_ff.speed        <= speed_ff;
         rsp_ff.rejected     <= rejected_ff;
         rsp_ff.empty_res    <= empty_ff;
         rsp_ff.vector_total <= total_ff;
      end
   end

   always_comb begin
      sts.clr_last  = (32'(clr_ff) == CELLS - 1);
      sts.mode      = mode_ff;
      sts.empty     = oob_ff || (rd_ff.count == 16'd0);
      sts.div_last  = (32'(iter_ff) == DIV_STEPS - 1);
      sts.sqrt_last = (32'(iter_ff) == SQRT_STEPS - 1);
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

/* design/grid_vector_bin_average_top.sv */
// Top level of the grid vector bin averaging block: joins controller and
// datapath. Depends on gvba_pkg, gvba_ctrl, gvba_dp.
`default_nettype none
// After reset the block sweeps its 1024-cell store to zero, one cell a cycle,
// and takes no item until the sweep is done (CSR writes are taken). One item
// at a time: an add (mode 0) goes through address, memory read and
// read-modify-write before its result is loaded. A cell readout (mode 1) runs
// the 33-step bit-serial divider and the 24-step bit-serial square root; an
// empty cell skips both. A finished result sits in the output register while
// the next item is accepted once it is taken or the register is free.
module grid_vector_bin_average_top import gvba_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   gvba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gvba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
`default_nettype wire

/* design/gvba_check.sv */
// Port-level checker for the grid vector bin averaging block, bound to the
// top level. Depends on gvba_pkg.
`default_nettype none
module gvba_check import gvba_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_mode_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.binned || rsp_data.empty_res || rsp_data.rejected) |->
         rsp_data.mean_y == 16'sd0 && rsp_data.mean_z == 16'sd0 &&
         rsp_data.speed == 16'd0)
      else $error("mean or speed set on add, empty or rejected beat");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid && !rsp_stall) && !$past(reset) |->
         rsp_data.vector_total >= $past(rsp_data.vector_total))
      else $error("vector total went down");

endmodule

bind grid_vector_bin_average_top gvba_check u_gvba_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
